FILE: sv/ftb_pkg.sv
`default_nettype none
package ftb_pkg;

  // Pixel and window geometry
  localparam int DATA_W   = 8;
  localparam int HIST     = 8;
  localparam int NUM_PAIR = 4;
  localparam int NUM_COEF = 5;
  localparam int PAIR_W   = DATA_W + 1;

  // Default fraction width of the coefficients
  localparam int COEF_FRAC_BITS_DEF = 17;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_OUTER  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_SECOND = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_THIRD  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_FOURTH = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COEF_CENTER = 3'd5;

  // Reset values: threshold, then coefficients from outer tap to center tap
  localparam logic [DATA_W-1:0] THRESHOLD_RESET = 8'd128;
  localparam logic [NUM_COEF-1:0][CFG_DATA_W-1:0] COEF_RESET = {
    32'd45057, 32'd31628, 32'd10227, 32'd1136, 32'd33
  };

  // Output word layout
  localparam int OUT_TDATA_W = 24;

  // Window after the pre-add of mirrored taps
  typedef struct packed {
    logic [DATA_W-1:0]                 pixel;
    logic [DATA_W-1:0]                 center;
    logic [NUM_PAIR-1:0][PAIR_W-1:0]   pair;
  } ftb_win_t;

endpackage
`default_nettype wire

FILE: sv/fir_threshold_binarizer.sv
`default_nettype none
// Symmetric 9-tap low-pass filter over an 8-bit pixel stream with a threshold
// flag. Each accepted pixel yields one output word holding the pixel itself,
// the filtered value (weighted sum of the current pixel and the eight before
// it, shifted right by COEF_FRAC_BITS and saturated at 255) and a flag that
// is set when the exact sum exceeds the threshold shifted left by
// COEF_FRAC_BITS. The delay line starts at zero, so results begin with the
// first pixel. One pixel is accepted every clock until a stall on the
// output has filled the pipeline bubbles and in_tready drops; each word
// passes through the pre-add, multiply, partial-sum and result registers.
// Threshold and the five coefficients (outer tap to center tap) are written
// over the APB port at byte addresses 0x00 to 0x14; the user must write
// them only while no word is in flight, which the block does not enforce.
module fir_threshold_binarizer #(
  parameter int COEF_FRAC_BITS = ftb_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ftb_pkg::DATA_W-1:0]         in_tdata,   // [7:0] pixel
  // Output stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [ftb_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [7:0] pixel_echo,
                                                              // [15:8] filtered,
                                                              // [16] above, rest zero
  // Configuration port
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [ftb_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [ftb_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic      [ftb_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                    cfg_pready
);

  logic [ftb_pkg::DATA_W-1:0]                         threshold;
  logic [ftb_pkg::NUM_COEF-1:0][COEF_FRAC_BITS-1:0]   coef;
  logic                                               win_valid;
  logic                                               win_ready;
  ftb_pkg::ftb_win_t                                  win;
  logic [ftb_pkg::DATA_W-1:0]                         res_pixel;
  logic [ftb_pkg::DATA_W-1:0]                         res_filtered;
  logic                                               res_above;

  assign cfg_pready = 1'b1;

  ftb_cfg_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .threshold (threshold),
    .coef      (coef)
  );

  ftb_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pixel  (in_tdata),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win)
  );

  ftb_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .win_valid    (win_valid),
    .win_ready    (win_ready),
    .win          (win),
    .threshold    (threshold),
    .coef         (coef),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res_pixel    (res_pixel),
    .res_filtered (res_filtered),
    .res_above    (res_above)
  );

  // Pack the output word
  assign out_tdata = ftb_pkg::OUT_TDATA_W'({res_above, res_filtered, res_pixel});

  // Input may only stall when every stage is full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while pipeline has room");

  // A filtered value above the threshold implies the flag
  a_flag_from_filtered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[15:8] > threshold)) |-> out_tdata[16])
    else $error("flag clear although filtered value exceeds threshold");

  // The flag implies a filtered value at least at the threshold
  a_filtered_from_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[16]) |-> (out_tdata[15:8] >= threshold))
    else $error("flag set although filtered value is below threshold");

  // No output word right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

FILE: sv/ftb_cfg_regs.sv
`default_nettype none
module ftb_cfg_regs #(
  parameter int COEF_FRAC_BITS = ftb_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       psel,
  input  wire logic                                       penable,
  input  wire logic                                       pwrite,
  input  wire logic [ftb_pkg::CFG_ADDR_W-1:0]             paddr,
  input  wire logic [ftb_pkg::CFG_DATA_W-1:0]             pwdata,
  output logic      [ftb_pkg::CFG_DATA_W-1:0]             prdata,
  output logic      [ftb_pkg::DATA_W-1:0]                 threshold,
  output logic      [ftb_pkg::NUM_COEF-1:0][COEF_FRAC_BITS-1:0] coef
);

  logic [ftb_pkg::DATA_W-1:0]                         thr_r;
  logic [ftb_pkg::NUM_COEF-1:0][COEF_FRAC_BITS-1:0]   coef_r;
  logic [ftb_pkg::REG_IDX_W-1:0]                      idx;
  logic [ftb_pkg::REG_IDX_W-1:0]                      cidx;
  logic                                               wr_en;

  assign idx   = paddr[ftb_pkg::CFG_ADDR_W-1:2];
  assign cidx  = idx - ftb_pkg::REG_COEF_OUTER;
  assign wr_en = psel & penable & pwrite;

  // Write registers, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ftb_pkg::THRESHOLD_RESET;
      for (int k = 0; k < ftb_pkg::NUM_COEF; k++) begin
        coef_r[k] <= COEF_FRAC_BITS'(ftb_pkg::COEF_RESET[k]);
      end
    end else if (wr_en) begin
      unique case (idx)
        ftb_pkg::REG_THRESHOLD: begin
          thr_r <= pwdata[ftb_pkg::DATA_W-1:0];
        end
        ftb_pkg::REG_COEF_OUTER, ftb_pkg::REG_COEF_SECOND, ftb_pkg::REG_COEF_THIRD,
        ftb_pkg::REG_COEF_FOURTH, ftb_pkg::REG_COEF_CENTER: begin
          coef_r[cidx] <= pwdata[COEF_FRAC_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      ftb_pkg::REG_THRESHOLD: begin
        prdata = ftb_pkg::CFG_DATA_W'(thr_r);
      end
      ftb_pkg::REG_COEF_OUTER, ftb_pkg::REG_COEF_SECOND, ftb_pkg::REG_COEF_THIRD,
      ftb_pkg::REG_COEF_FOURTH, ftb_pkg::REG_COEF_CENTER: begin
        prdata = ftb_pkg::CFG_DATA_W'(coef_r[cidx]);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign threshold = thr_r;
  assign coef      = coef_r;

endmodule
`default_nettype wire

FILE: sv/ftb_window.sv
`default_nettype none
module ftb_window (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ftb_pkg::DATA_W-1:0]  in_pixel,
  output logic                             win_valid,
  input  wire logic                        win_ready,
  output ftb_pkg::ftb_win_t                win
);

  // dl_r[0] is the oldest pixel
  logic [ftb_pkg::HIST-1:0][ftb_pkg::DATA_W-1:0] dl_r;
  logic [ftb_pkg::HIST:0][ftb_pkg::DATA_W-1:0]   taps;
  ftb_pkg::ftb_win_t                             win_r;
  ftb_pkg::ftb_win_t                             win_nxt;
  logic                                          valid_r;
  logic                                          accept;

  assign in_ready = !valid_r | win_ready;
  assign accept   = in_valid & in_ready;

  // Full window: eight stored pixels plus the incoming one
  always_comb begin
    for (int i = 0; i < ftb_pkg::HIST; i++) begin
      taps[i] = dl_r[i];
    end
    taps[ftb_pkg::HIST] = in_pixel;
  end

  // Pre-add mirrored taps
  always_comb begin
    win_nxt.pixel  = in_pixel;
    win_nxt.center = taps[ftb_pkg::NUM_PAIR];
    for (int k = 0; k < ftb_pkg::NUM_PAIR; k++) begin
      win_nxt.pair[k] = ftb_pkg::PAIR_W'(taps[k]) + ftb_pkg::PAIR_W'(taps[ftb_pkg::HIST - k]);
    end
  end

  // Shift the delay line on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r <= '0;
    end else if (accept) begin
      for (int i = 0; i < ftb_pkg::HIST - 1; i++) begin
        dl_r[i] <= dl_r[i + 1];
      end
      dl_r[ftb_pkg::HIST-1] <= in_pixel;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  assign win_valid = valid_r;
  assign win       = win_r;

endmodule
`default_nettype wire

FILE: sv/ftb_mac.sv
`default_nettype none
module ftb_mac #(
  parameter int COEF_FRAC_BITS = ftb_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst_n,
  input  wire logic                                             win_valid,
  output logic                                                  win_ready,
  input  wire ftb_pkg::ftb_win_t                                win,
  input  wire logic [ftb_pkg::DATA_W-1:0]                       threshold,
  input  wire logic [ftb_pkg::NUM_COEF-1:0][COEF_FRAC_BITS-1:0] coef,
  output logic                                                  res_valid,
  input  wire logic                                             res_ready,
  output logic      [ftb_pkg::DATA_W-1:0]                       res_pixel,
  output logic      [ftb_pkg::DATA_W-1:0]                       res_filtered,
  output logic                                                  res_above
);

  localparam int PW = COEF_FRAC_BITS + ftb_pkg::PAIR_W;   // one product
  localparam int HW = PW + 1;                             // sum of two products
  localparam int SW = COEF_FRAC_BITS + 12;                // full sum
  localparam int FW = ftb_pkg::DATA_W;

  // Product stage
  logic                                     vb_r;
  logic [ftb_pkg::NUM_COEF-1:0][PW-1:0]     prod_r;
  logic [FW-1:0]                            pix_b_r;
  logic                                     rdy_b;

  // Partial sum stage
  logic                                     vc_r;
  logic [HW-1:0]                            s01_r;
  logic [HW-1:0]                            s23_r;
  logic [PW-1:0]                            p4_r;
  logic [FW-1:0]                            pix_c_r;
  logic                                     rdy_c;

  // Result stage
  logic                                     vo_r;
  logic [FW-1:0]                            pix_o_r;
  logic [FW-1:0]                            filt_r;
  logic                                     above_r;
  logic                                     rdy_o;

  logic [SW-1:0]                            total;
  logic [SW-1:0]                            limit;
  logic [FW-1:0]                            filt_nxt;
  logic                                     above_nxt;

  assign rdy_o     = !vo_r | res_ready;
  assign rdy_c     = !vc_r | rdy_o;
  assign rdy_b     = !vb_r | rdy_c;
  assign win_ready = rdy_b;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy_b) begin
        vb_r <= win_valid;
      end
      if (rdy_c) begin
        vc_r <= vb_r;
      end
      if (rdy_o) begin
        vo_r <= vc_r;
      end
    end
  end

  // Multiply each pair and the center tap by its weight
  always_ff @(posedge clk) begin
    if (rdy_b && win_valid) begin
      for (int k = 0; k < ftb_pkg::NUM_PAIR; k++) begin
        prod_r[k] <= PW'(win.pair[k]) * PW'(coef[k]);
      end
      prod_r[ftb_pkg::NUM_PAIR] <= PW'(win.center) * PW'(coef[ftb_pkg::NUM_PAIR]);
      pix_b_r <= win.pixel;
    end
  end

  // Add products two by two, carry the center product alone
  always_ff @(posedge clk) begin
    if (rdy_c && vb_r) begin
      s01_r   <= HW'(prod_r[0]) + HW'(prod_r[1]);
      s23_r   <= HW'(prod_r[2]) + HW'(prod_r[3]);
      p4_r    <= prod_r[4];
      pix_c_r <= pix_b_r;
    end
  end

  // Final sum, saturate and compare against the shifted threshold
  assign total = SW'(s01_r) + SW'(s23_r) + SW'(p4_r);
  assign limit = SW'({threshold, {COEF_FRAC_BITS{1'b0}}});

  always_comb begin
    if (|total[SW-1:COEF_FRAC_BITS+FW]) begin
      filt_nxt = {FW{1'b1}};
    end else begin
      filt_nxt = total[COEF_FRAC_BITS+FW-1:COEF_FRAC_BITS];
    end
    above_nxt = total > limit;
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vc_r) begin
      pix_o_r <= pix_c_r;
      filt_r  <= filt_nxt;
      above_r <= above_nxt;
    end
  end

  assign res_valid    = vo_r;
  assign res_pixel    = pix_o_r;
  assign res_filtered = filt_r;
  assign res_above    = above_r;

endmodule
`default_nettype wire
